>>> hdl/rafnh_pkg.sv
// Package for the radio API frame node handler.
// Types, constants and reset values shared by all modules. No dependencies.
package rafnh_pkg;
  localparam int NODES = 4;
  localparam int NODE_W = 2;
  localparam int NUM_CFG = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int REQ_LEN = 19;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_VALID = 3'd4;

  localparam logic [63:0] ADDR0_RST = 64'd5526146545289993;
  localparam logic [63:0] ADDR1_RST = 64'd5526146545290005;
  localparam logic [63:0] ADDR2_RST = 64'd5526146545290218;
  localparam logic [63:0] ADDR3_RST = 64'd0;
  localparam logic [3:0]  VALID_RST = 4'd7;

  localparam logic [15:0] CMD_TP = 16'h5450;
  localparam logic [15:0] CMD_PV = 16'h2556;

  localparam logic [2:0] ST_IO      = 3'd0;
  localparam logic [2:0] ST_TEMP    = 3'd1;
  localparam logic [2:0] ST_BATT    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;
  localparam logic [2:0] ST_BADSUM  = 3'd5;

  // Finished frame handed from the parser to the back end.
  typedef struct packed {
    logic        kind;
    logic        sum_ok;
    logic [63:0] src;
    logic [15:0] cmd;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
  } frame_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  status;
    logic [1:0]  node_index;
    logic [15:0] resistive;
    logic [15:0] capacitive;
    logic [15:0] temperature;
    logic [15:0] battery;
  } result_t;

  // Fixed bytes of the battery request frame; address bytes 5..12 and checksum filled later.
  function automatic logic [7:0] req_const(input logic [4:0] pos);
    logic [7:0] v;
    v = 8'h00;
    unique case (pos)
      5'd0: v = 8'h7E;
      5'd1: v = 8'h00;
      5'd2: v = 8'h0F;
      5'd3: v = 8'h17;
      5'd4: v = 8'h01;
      5'd13: v = 8'hFF;
      5'd14: v = 8'hFE;
      5'd15: v = 8'h02;
      5'd16: v = 8'h25;
      5'd17: v = 8'h56;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage

>>> hdl/rafnh_if.sv
// Valid/ready channel interfaces for input bytes and result words.
// No package dependencies.
interface rafnh_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       start_req;
  modport source (output valid, kind, data_byte, start_req, input ready);
  modport sink   (input valid, kind, data_byte, start_req, output ready);
endinterface

interface rafnh_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  status;
  logic [1:0]  node_index;
  logic [15:0] resistive;
  logic [15:0] capacitive;
  logic [15:0] temperature;
  logic [15:0] battery;
  modport source (output valid, out_kind, tx_byte, last, status, node_index, resistive,
                  capacitive, temperature, battery, input ready);
  modport sink   (input valid, out_kind, tx_byte, last, status, node_index, resistive,
                  capacitive, temperature, battery, output ready);
endinterface

>>> hdl/radio_api_frame_node_handler_unit.sv
// Radio API frame node handler: top level.
// Depends on rafnh_pkg, rafnh_if, rafnh_parser, rafnh_queue, rafnh_backend.
//
// Usage: received frame bytes enter on the in_ channel (kind, data_byte,
// start_req), one word per cycle while in_ready is high. Each completed
// frame gives a status report word on the out_ channel, then for a stored
// IO sample or temperature a 19-word battery request frame (out_kind 1), the
// last word flagged. A frame is registered by the parser and the queue before
// the back end registers its report. Throughput: one input byte per cycle; a
// request occupies the back end while the parser keeps taking bytes into a
// 4-entry frame queue. Input stalls only when that queue holds three frames.
// A stalled receiver holds the output word; the queue absorbs the backlog.
// Node addresses and the enable mask are written through cfg_ at index 0..4;
// write them only while idle (not enforced here). Synchronous reset restores
// default addresses, clears stored readings and drops any frame in progress.
module radio_api_frame_node_handler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rafnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rafnh_pkg::CFG_DATA_W-1:0]     cfg_data,
  rafnh_in_if.sink                             in_ch,
  rafnh_out_if.source                          out_ch
);
  logic              pf_valid, pf_ready, q_valid, q_ready;
  rafnh_pkg::frame_t pf_data, q_data;
  rafnh_pkg::result_t res;

  rafnh_parser u_parser (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .kind(in_ch.kind),
    .data_byte(in_ch.data_byte), .start_req(in_ch.start_req),
    .fr_valid(pf_valid), .fr_ready(pf_ready), .fr_data(pf_data)
  );

  rafnh_queue u_queue (
    .clk, .rst_n,
    .wr_valid(pf_valid), .wr_ready(pf_ready), .wr_data(pf_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  rafnh_backend u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .fr_valid(q_valid), .fr_ready(q_ready), .fr_data(q_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res_data(res)
  );

  assign out_ch.out_kind    = res.out_kind;
  assign out_ch.tx_byte     = res.tx_byte;
  assign out_ch.last        = res.last;
  assign out_ch.status      = res.status;
  assign out_ch.node_index  = res.node_index;
  assign out_ch.resistive   = res.resistive;
  assign out_ch.capacitive  = res.capacitive;
  assign out_ch.temperature = res.temperature;
  assign out_ch.battery     = res.battery;
endmodule

>>> hdl/rafnh_parser.sv
// Front end: byte-position parser that collects one frame's fields.
// Depends on rafnh_pkg. Emits a frame_t word when the checksum byte arrives.
module rafnh_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [7:0]            data_byte,
  input  logic                  start_req,
  output logic                  fr_valid,
  input  logic                  fr_ready,
  output rafnh_pkg::frame_t     fr_data
);
  logic [16:0] pos_r, pos_nxt;
  logic        kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [63:0] src_r, src_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [15:0] w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  logic        acc, fin;

  assign in_ready = fr_ready;
  assign acc = in_valid && in_ready;

  always_comb begin
    pos_nxt = pos_r; kind_nxt = kind_r; len_nxt = len_r; sum_nxt = sum_r;
    src_nxt = src_r; cmd_nxt = cmd_r; w0_nxt = w0_r; w1_nxt = w1_r; w2_nxt = w2_r;
    fin = 1'b0;
    if (acc) begin
      if (start_req) begin
        pos_nxt = 17'd1; kind_nxt = kind; len_nxt = '0; sum_nxt = '0;
        src_nxt = '0; cmd_nxt = '0; w0_nxt = '0; w1_nxt = '0; w2_nxt = '0;
      end else if (pos_r != '0) begin
        if (pos_r == 17'd1) len_nxt = {data_byte, 8'h00};
        if (pos_r == 17'd2) len_nxt = {len_r[15:8], data_byte};
        if (pos_r >= 17'd3) sum_nxt = sum_r + data_byte;
        if (!kind_r) begin
          if (pos_r >= 17'd4 && pos_r <= 17'd11) src_nxt = {src_r[55:0], data_byte};
          if (pos_r == 17'd19) w0_nxt[15:8] = data_byte;
          if (pos_r == 17'd20) w0_nxt[7:0]  = data_byte;
          if (pos_r == 17'd21) w1_nxt[15:8] = data_byte;
          if (pos_r == 17'd22) w1_nxt[7:0]  = data_byte;
          if (pos_r == 17'd23) w2_nxt[15:8] = data_byte;
          if (pos_r == 17'd24) w2_nxt[7:0]  = data_byte;
        end else begin
          if (pos_r >= 17'd5 && pos_r <= 17'd12) src_nxt = {src_r[55:0], data_byte};
          if (pos_r == 17'd15) cmd_nxt[15:8] = data_byte;
          if (pos_r == 17'd16) cmd_nxt[7:0]  = data_byte;
          if (pos_r == 17'd18) w0_nxt[15:8] = data_byte;
          if (pos_r == 17'd19) w0_nxt[7:0]  = data_byte;
        end
        if (pos_r >= 17'd3 && pos_r == ({1'b0, len_r} + 17'd3)) begin
          fin = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 17'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; kind_r <= 1'b0; len_r <= '0;
      fr_valid <= 1'b0;
    end else begin
      pos_r <= pos_nxt; kind_r <= kind_nxt; len_r <= len_nxt;
      fr_valid <= fin;
    end
    sum_r <= sum_nxt; src_r <= src_nxt; cmd_r <= cmd_nxt;
    w0_r <= w0_nxt; w1_r <= w1_nxt; w2_r <= w2_nxt;
    if (fin) begin
      fr_data <= '{kind: kind_r, sum_ok: (sum_nxt == 8'hFF), src: src_nxt, cmd: cmd_nxt,
                   w0: w0_nxt, w1: w1_nxt, w2: w2_nxt};
    end
  end
endmodule

>>> hdl/rafnh_queue.sv
// Short frame queue between parser and back end.
// Depends on rafnh_pkg. Keeps space for one in-flight word beyond ready.
module rafnh_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  rafnh_pkg::frame_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output rafnh_pkg::frame_t rd_data
);
  rafnh_pkg::frame_t mem_r [rafnh_pkg::QUEUE_DEPTH];
  logic [rafnh_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [rafnh_pkg::QPTR_W:0]   cnt_r;
  logic do_wr, do_rd;

  assign do_wr = wr_valid;
  assign do_rd = rd_valid && rd_ready;
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  // parser word lands in the cycle after its input byte is taken: reserve one slot
  assign wr_ready = cnt_r < (rafnh_pkg::QUEUE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'b00, do_wr} - {2'b00, do_rd};
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_valid |-> cnt_r != rafnh_pkg::QUEUE_DEPTH) else $error("queue overflow");
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ready |-> cnt_r < rafnh_pkg::QUEUE_DEPTH) else $error("ready without room");
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !do_rd) else $error("read while empty");
endmodule

>>> hdl/rafnh_backend.sv
// Back end: node match, per-node reading store, report and request sequencer.
// Depends on rafnh_pkg. Drives a registered result word.
module rafnh_backend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rafnh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rafnh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               fr_valid,
  output logic                               fr_ready,
  input  rafnh_pkg::frame_t                  fr_data,
  output logic                               res_valid,
  input  logic                               res_ready,
  output rafnh_pkg::result_t                 res_data
);
  logic [63:0] addr_r [rafnh_pkg::NODES];
  logic [3:0]  nvalid_r;
  logic [15:0] res_st_r [rafnh_pkg::NODES];
  logic [15:0] cap_st_r [rafnh_pkg::NODES];
  logic [15:0] tmp_st_r [rafnh_pkg::NODES];
  logic [15:0] bat_st_r [rafnh_pkg::NODES];

  // tx sequencer
  logic        tx_busy_r;
  logic [4:0]  tx_pos_r;
  logic [1:0]  tx_node_r;
  logic [7:0]  tx_sum_r;

  logic        slot_free, take, match;
  logic [1:0]  mnode;
  logic [2:0]  st;
  logic        wr_io, wr_tp, wr_bv, send_req;
  logic [7:0]  tx_b;
  logic [63:0] ta;
  rafnh_pkg::result_t rep, tx_w;

  assign slot_free = !res_valid || res_ready;
  assign take = fr_valid && !tx_busy_r && slot_free;
  assign fr_ready = !tx_busy_r && slot_free;

  always_comb begin
    match = 1'b0; mnode = '0;
    for (int i = rafnh_pkg::NODES - 1; i >= 0; i--) begin
      if (nvalid_r[i] && addr_r[i] == fr_data.src) begin
        match = 1'b1; mnode = i[1:0];
      end
    end
  end

  always_comb begin
    wr_io = 1'b0; wr_tp = 1'b0; wr_bv = 1'b0; send_req = 1'b0;
    if (!fr_data.kind && !fr_data.sum_ok) st = rafnh_pkg::ST_BADSUM;
    else if (!match) st = rafnh_pkg::ST_NOMATCH;
    else if (!fr_data.kind) begin st = rafnh_pkg::ST_IO; wr_io = 1'b1; send_req = 1'b1; end
    else if (fr_data.cmd == rafnh_pkg::CMD_TP) begin
      st = rafnh_pkg::ST_TEMP; wr_tp = 1'b1; send_req = 1'b1;
    end else if (fr_data.cmd == rafnh_pkg::CMD_PV) begin
      st = rafnh_pkg::ST_BATT; wr_bv = 1'b1;
    end else st = rafnh_pkg::ST_UNKNOWN;
  end

  always_comb begin
    rep = '0;
    rep.status = st;
    rep.last = !send_req;
    if (st != rafnh_pkg::ST_BADSUM && st != rafnh_pkg::ST_NOMATCH) begin
      rep.node_index = mnode;
      rep.resistive   = wr_io ? fr_data.w0 : res_st_r[mnode];
      rep.capacitive  = wr_io ? fr_data.w1 : cap_st_r[mnode];
      rep.temperature = wr_io ? fr_data.w2 : (wr_tp ? fr_data.w0 : tmp_st_r[mnode]);
      rep.battery     = wr_bv ? fr_data.w0 : bat_st_r[mnode];
    end
  end

  always_comb begin
    ta = addr_r[tx_node_r];
    tx_b = rafnh_pkg::req_const(tx_pos_r);
    if (tx_pos_r >= 5'd5 && tx_pos_r <= 5'd12)
      tx_b = ta[8'(7'd63 - 7'(({2'b00, tx_pos_r} - 7'd5) << 3)) -: 8];
    if (tx_pos_r == 5'd18) tx_b = 8'hFF - tx_sum_r;
    tx_w = '0;
    tx_w.out_kind = 1'b1;
    tx_w.tx_byte = tx_b;
    tx_w.last = (tx_pos_r == 5'(rafnh_pkg::REQ_LEN - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r[0] <= rafnh_pkg::ADDR0_RST; addr_r[1] <= rafnh_pkg::ADDR1_RST;
      addr_r[2] <= rafnh_pkg::ADDR2_RST; addr_r[3] <= rafnh_pkg::ADDR3_RST;
      nvalid_r <= rafnh_pkg::VALID_RST;
      for (int i = 0; i < rafnh_pkg::NODES; i++) begin
        res_st_r[i] <= '0; cap_st_r[i] <= '0; tmp_st_r[i] <= '0; bat_st_r[i] <= '0;
      end
      tx_busy_r <= 1'b0; tx_pos_r <= '0; tx_node_r <= '0; tx_sum_r <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < rafnh_pkg::CFG_NODE_VALID) addr_r[cfg_index[1:0]] <= cfg_data;
        else if (cfg_index == rafnh_pkg::CFG_NODE_VALID) nvalid_r <= cfg_data[3:0];
      end
      if (take) begin
        res_valid <= 1'b1;
        res_data <= rep;
        if (wr_io) begin
          res_st_r[mnode] <= fr_data.w0; cap_st_r[mnode] <= fr_data.w1;
          tmp_st_r[mnode] <= fr_data.w2;
        end
        if (wr_tp) tmp_st_r[mnode] <= fr_data.w0;
        if (wr_bv) bat_st_r[mnode] <= fr_data.w0;
        if (send_req) begin
          tx_busy_r <= 1'b1; tx_pos_r <= '0; tx_node_r <= mnode; tx_sum_r <= '0;
        end
      end else if (tx_busy_r && slot_free) begin
        res_valid <= 1'b1;
        res_data <= tx_w;
        if (tx_pos_r >= 5'd3) tx_sum_r <= tx_sum_r + tx_b;
        if (tx_pos_r == 5'(rafnh_pkg::REQ_LEN - 1)) tx_busy_r <= 1'b0;
        tx_pos_r <= tx_pos_r + 5'd1;
      end else if (slot_free) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tx_busy_r |-> !take) else $error("frame taken during request");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_busy_r |-> tx_pos_r < 5'(rafnh_pkg::REQ_LEN)) else $error("request overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid && $stable(res_data)) else $error("result lost");
endmodule
